// File: sv/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared widths, register codes, distance scaling constants and the bar-graph
// level mapping for the parking distance unit.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam int unsigned TICKS_W   = 10;
	localparam int unsigned TIMEOUT_W = 15;
	localparam int unsigned LIMIT_W   = 12;
	localparam int unsigned DIST_W    = 14;
	localparam int unsigned TENTHS_W  = 12;
	localparam int unsigned LEVEL_W   = 4;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned BEEP_W    = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 15;

	localparam int unsigned DEF_SAMPLES = 5;
	localparam int unsigned DEF_TICK_US = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 15'd13000;
	localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 12'd2000;

	// tenths of cm = us * 343 / 2000
	localparam longint unsigned SOUND_NUM = 343;
	localparam longint unsigned SCALE_DEN = 2000;

	// reciprocal for the timeout path, exact for any 15-bit value
	localparam int unsigned     TO_SHIFT = 27;
	localparam longint unsigned TO_RECIP =
		((SOUND_NUM << TO_SHIFT) + SCALE_DEN - 64'd1) / SCALE_DEN;
	localparam int unsigned     TO_RECIP_W = 25;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMEOUT = 1'd0,
		REG_LIMIT   = 1'd1
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_BEEP   = 2'd0,
		MODE_STEADY = 2'd1,
		MODE_OFF    = 2'd2
	} buzz_mode_t;

	// band edges in tenths of cm
	localparam logic [DIST_W-1:0] D_10CM = 14'd100;
	localparam logic [DIST_W-1:0] D_15CM = 14'd150;
	localparam logic [DIST_W-1:0] D_20CM = 14'd200;
	localparam logic [DIST_W-1:0] D_25CM = 14'd250;
	localparam logic [DIST_W-1:0] D_30CM = 14'd300;
	localparam logic [DIST_W-1:0] D_35CM = 14'd350;
	localparam logic [DIST_W-1:0] D_40CM = 14'd400;
	localparam logic [DIST_W-1:0] D_50CM = 14'd500;

	localparam logic [BEEP_W-1:0] BEEP_15CM = 16'd62000;
	localparam logic [BEEP_W-1:0] BEEP_20CM = 16'd58000;
	localparam logic [BEEP_W-1:0] BEEP_25CM = 16'd52000;
	localparam logic [BEEP_W-1:0] BEEP_30CM = 16'd46000;
	localparam logic [BEEP_W-1:0] BEEP_40CM = 16'd40000;
	localparam logic [BEEP_W-1:0] BEEP_50CM = 16'd34000;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd8;
	localparam logic [LEVEL_W-1:0] LEVEL_NONE = 4'd0;

	typedef struct packed {
		logic [BEEP_W-1:0]   beep_reload;
		buzz_mode_t          buzzer_mode;
		logic [LEVEL_W-1:0]  rear_level;
		logic [LEVEL_W-1:0]  front_level;
		logic                rear_far;
		logic [TENTHS_W-1:0] rear_tenths;
		logic                front_far;
		logic [TENTHS_W-1:0] front_tenths;
	} report_t;

	function automatic logic [LEVEL_W-1:0] bar_level(input logic [DIST_W-1:0] d);
		logic [LEVEL_W-1:0] lv;
		if (d <= D_10CM)      lv = 4'd8;
		else if (d <= D_15CM) lv = 4'd7;
		else if (d <= D_20CM) lv = 4'd6;
		else if (d <= D_25CM) lv = 4'd5;
		else if (d <= D_30CM) lv = 4'd4;
		else if (d <= D_35CM) lv = 4'd3;
		else if (d <= D_40CM) lv = 4'd2;
		else if (d <= D_50CM) lv = 4'd1;
		else                  lv = 4'd0;
		return lv;
	endfunction

endpackage

// File: sv/upd_accum.sv
// ----------------------------------------------------------------------------
// upd_accum
// Input register and per-sensor echo accumulator; hands on one value to scale
// for each finished sensor (the echo sum, or the timeout in microseconds).
// ----------------------------------------------------------------------------
module upd_accum #(
	parameter int unsigned SAMPLES = upd_pkg::DEF_SAMPLES,
	parameter int unsigned TICK_US = upd_pkg::DEF_TICK_US,
	parameter int unsigned X_W     = 17
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [upd_pkg::TICKS_W-1:0]   in_ticks,
	input  logic                          in_timed_out,
	input  logic [upd_pkg::TIMEOUT_W-1:0] timeout_us,
	output logic                          v_s2,
	input  logic                          take_s2,
	output logic                          to_s2,
	output logic [X_W-1:0]                x_s2
);
	import upd_pkg::*;

	localparam int unsigned X_MAX = SAMPLES * ((1 << TICKS_W) - 1) * TICK_US;
	localparam int unsigned SUM_W = $clog2(X_MAX + 1);
	localparam int unsigned CNT_W = $clog2(SAMPLES + 1);

	logic                v_s1;
	logic [TICKS_W-1:0]  ticks_s1;
	logic                to_s1;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [SUM_W-1:0]    sum_add;
	logic [CNT_W:0]      cnt_nxt;
	logic                proc;
	logic                done;

	assign in_ready = !v_s1 || take_s2;
	assign proc     = v_s1 && take_s2;
	assign sum_add  = sum_q + SUM_W'(ticks_s1 * TICK_US);
	assign cnt_nxt  = {1'b0, cnt_q} + (CNT_W+1)'(1);
	assign done     = to_s1 || (cnt_nxt == (CNT_W+1)'(SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (take_s2)
				v_s2 <= v_s1 && done;
			if (proc) begin
				if (done) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_add;
					cnt_q <= cnt_nxt[CNT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ticks_s1 <= in_ticks;
			to_s1    <= in_timed_out;
		end
		if (proc && done) begin
			to_s2 <= to_s1;
			x_s2  <= to_s1 ? X_W'(timeout_us) : X_W'(sum_add);
		end
	end

endmodule

// File: sv/upd_scale.sv
// ----------------------------------------------------------------------------
// upd_scale
// Turns microseconds into tenths of cm by reciprocal multiplication: the
// averaged echo sum or the raw timeout, each with its own exact constant.
// ----------------------------------------------------------------------------
module upd_scale #(
	parameter int unsigned SAMPLES = upd_pkg::DEF_SAMPLES,
	parameter int unsigned TICK_US = upd_pkg::DEF_TICK_US,
	parameter int unsigned X_W     = 17
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       v_s2,
	output logic                       take_s2,
	input  logic                       to_s2,
	input  logic [X_W-1:0]             x_s2,
	output logic                       v_s3,
	input  logic                       take_s3,
	output logic [upd_pkg::DIST_W-1:0] dist_s3
);
	import upd_pkg::*;

	localparam int unsigned     X_MAX     = SAMPLES * ((1 << TICKS_W) - 1) * TICK_US;
	localparam int unsigned     SUM_W     = $clog2(X_MAX + 1);
	localparam longint unsigned EC_DEN    = SCALE_DEN * SAMPLES;
	// 2^shift > 2 * den * max sum keeps the rounded-up reciprocal exact
	localparam int unsigned     EC_SHIFT  = $clog2(EC_DEN * longint'(X_MAX)) + 1;
	localparam longint unsigned EC_RECIP  =
		((SOUND_NUM << EC_SHIFT) + EC_DEN - 64'd1) / EC_DEN;
	localparam int unsigned     EC_PROD_W = EC_SHIFT + DIST_W;
	localparam int unsigned     TO_PROD_W = TO_SHIFT + DIST_W;

	logic [EC_PROD_W-1:0] ec_prod;
	logic [TO_PROD_W-1:0] to_prod;
	logic [DIST_W-1:0]    dist_nxt;

	assign take_s2  = !v_s2 || take_s3;
	assign ec_prod  = EC_PROD_W'(x_s2[SUM_W-1:0]) * EC_PROD_W'(EC_RECIP);
	assign to_prod  = TO_PROD_W'(x_s2[TIMEOUT_W-1:0]) * TO_PROD_W'(TO_RECIP[TO_RECIP_W-1:0]);
	assign dist_nxt = to_s2 ? to_prod[TO_SHIFT +: DIST_W] : ec_prod[EC_SHIFT +: DIST_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (take_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3 && v_s2)
			dist_s3 <= dist_nxt;
	end

endmodule

// File: sv/upd_report.sv
// ----------------------------------------------------------------------------
// upd_report
// Pairs front and rear distances, derives limits, bar levels, buzzer mode and
// beep reload, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module upd_report (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        v_s3,
	output logic                        take_s3,
	input  logic [upd_pkg::DIST_W-1:0]  dist_s3,
	input  logic [upd_pkg::LIMIT_W-1:0] limit,
	output logic                        res_valid,
	input  logic                        res_ready,
	output upd_pkg::report_t            res
);
	import upd_pkg::*;

	logic                active_q;
	logic [DIST_W-1:0]   front_q;
	logic [BEEP_W-1:0]   beep_q;
	logic                res_valid_q;
	report_t             res_q;

	logic                out_free;
	logic                proc;
	logic [DIST_W-1:0]   rear;
	logic [DIST_W-1:0]   lim;
	logic [DIST_W-1:0]   nearest;
	logic [BEEP_W-1:0]   beep_nxt;
	buzz_mode_t          mode;
	report_t             res_nxt;

	assign out_free  = !res_valid_q || res_ready;
	assign take_s3   = !v_s3 || out_free;
	assign proc      = v_s3 && out_free;
	assign rear      = dist_s3;
	assign lim       = DIST_W'(limit);
	assign nearest   = (rear < front_q) ? rear : front_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// beep keeps its last value outside the bands, the 30 to 35 cm gap too
	always_comb begin
		beep_nxt = beep_q;
		if (nearest > D_10CM && nearest <= D_15CM)      beep_nxt = BEEP_15CM;
		else if (nearest > D_15CM && nearest <= D_20CM) beep_nxt = BEEP_20CM;
		else if (nearest > D_20CM && nearest <= D_25CM) beep_nxt = BEEP_25CM;
		else if (nearest > D_25CM && nearest <= D_30CM) beep_nxt = BEEP_30CM;
		else if (nearest > D_35CM && nearest <= D_40CM) beep_nxt = BEEP_40CM;
		else if (nearest > D_40CM && nearest <= D_50CM) beep_nxt = BEEP_50CM;
	end

	always_comb begin
		if (front_q <= D_10CM || rear <= D_10CM)
			mode = MODE_STEADY;
		else if (front_q > D_50CM && rear > D_50CM)
			mode = MODE_OFF;
		else
			mode = MODE_BEEP;
	end

	always_comb begin
		res_nxt.front_far    = front_q > lim;
		res_nxt.front_tenths = res_nxt.front_far ? limit : front_q[TENTHS_W-1:0];
		res_nxt.rear_far     = rear > lim;
		res_nxt.rear_tenths  = res_nxt.rear_far ? limit : rear[TENTHS_W-1:0];
		res_nxt.front_level  = bar_level(front_q);
		res_nxt.rear_level   = bar_level(rear);
		res_nxt.buzzer_mode  = mode;
		res_nxt.beep_reload  = beep_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			front_q     <= '0;
			beep_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (out_free)
				res_valid_q <= v_s3 && active_q;
			if (proc) begin
				active_q <= !active_q;
				if (!active_q)
					front_q <= dist_s3;
				else
					beep_q <= beep_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc && active_q)
			res_q <= res_nxt;
	end

endmodule

// File: sv/ultrasonic_parking_distance_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_parking_distance_unit
// Front/rear parking distance from echo beats: accumulate, scale, report.
// ----------------------------------------------------------------------------
// the last rear echo beat passes the s2, s3 and result registers to m_axis
// throughput: one echo beat per cycle while m_axis does not stall the stages,
//   set by the accumulator add loop
// reset: all stages empty, front sensor active, sums and beep value cleared,
//   timeout 13000 us and display limit 200.0 cm
module ultrasonic_parking_distance_unit #(
	parameter int unsigned SAMPLES = upd_pkg::DEF_SAMPLES,
	parameter int unsigned TICK_US = upd_pkg::DEF_TICK_US
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [15:0]                    s_axis_tdata,  // [9:0] echo_ticks
	input  logic [0:0]                     s_axis_tuser,  // [0] timed_out
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [11:0] front_tenths, [23:12] rear_tenths, [27:24] front_level,
	// [31:28] rear_level, [33:32] buzzer_mode, [49:34] beep_reload
	output logic [55:0]                    m_axis_tdata,
	output logic [1:0]                     m_axis_tuser,  // [0] front_far, [1] rear_far
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [upd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [upd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import upd_pkg::*;

	localparam int unsigned X_MAX = SAMPLES * ((1 << TICKS_W) - 1) * TICK_US;
	localparam int unsigned SUM_W = $clog2(X_MAX + 1);
	localparam int unsigned X_W   = (SUM_W > TIMEOUT_W) ? SUM_W : TIMEOUT_W;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic [LIMIT_W-1:0]   limit_q;

	logic                 v_s2;
	logic                 take_s2;
	logic                 to_s2;
	logic [X_W-1:0]       x_s2;
	logic                 v_s3;
	logic                 take_s3;
	logic [DIST_W-1:0]    dist_s3;
	report_t              res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			limit_q   <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_data[TIMEOUT_W-1:0];
				REG_LIMIT:   limit_q   <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	upd_accum #(
		.SAMPLES (SAMPLES),
		.TICK_US (TICK_US),
		.X_W     (X_W)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_ticks     (s_axis_tdata[TICKS_W-1:0]),
		.in_timed_out (s_axis_tuser[0]),
		.timeout_us   (timeout_q),
		.v_s2         (v_s2),
		.take_s2      (take_s2),
		.to_s2        (to_s2),
		.x_s2         (x_s2)
	);

	upd_scale #(
		.SAMPLES (SAMPLES),
		.TICK_US (TICK_US),
		.X_W     (X_W)
	) u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_s2    (v_s2),
		.take_s2 (take_s2),
		.to_s2   (to_s2),
		.x_s2    (x_s2),
		.v_s3    (v_s3),
		.take_s3 (take_s3),
		.dist_s3 (dist_s3)
	);

	upd_report u_report (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s3      (v_s3),
		.take_s3   (take_s3),
		.dist_s3   (dist_s3),
		.limit     (limit_q),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {6'b0, res.beep_reload, res.buzzer_mode, res.rear_level,
		res.front_level, res.rear_tenths, res.front_tenths};
	assign m_axis_tuser = {res.rear_far, res.front_far};

endmodule

// File: sv/upd_checker.sv
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks on the result stream of the parking distance unit.
// ----------------------------------------------------------------------------
module upd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);
	import upd_pkg::*;

	logic [LEVEL_W-1:0] front_level;
	logic [LEVEL_W-1:0] rear_level;
	logic [MODE_W-1:0]  mode;

	assign front_level = m_axis_tdata[27:24];
	assign rear_level  = m_axis_tdata[31:28];
	assign mode        = m_axis_tdata[33:32];

	// a stalled result beat stays up and unchanged
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (front_level <= LEVEL_MAX) && (rear_level <= LEVEL_MAX))
		else $error("bar level out of range");

	// steady tone exactly when one side is within 10 cm
	a_mode_steady: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((mode == MODE_STEADY) ==
			(front_level == LEVEL_MAX || rear_level == LEVEL_MAX)))
		else $error("steady buzzer does not match bar levels");

	a_mode_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((mode == MODE_OFF) ==
			(front_level == LEVEL_NONE && rear_level == LEVEL_NONE)))
		else $error("buzzer off does not match bar levels");

endmodule

bind ultrasonic_parking_distance_unit upd_checker u_upd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
